@@ rtl/iad_pkg.sv @@
`timescale 1ns / 1ps

package iad_pkg;

  // Operation codes carried on the command field
  typedef enum logic [4:0] {
    CMD_ADD   = 5'd0,
    CMD_ADDU  = 5'd1,
    CMD_SUBU  = 5'd2,
    CMD_AND   = 5'd3,
    CMD_OR    = 5'd4,
    CMD_SLT   = 5'd5,
    CMD_SLTU  = 5'd6,
    CMD_ADDI  = 5'd7,
    CMD_ADDIU = 5'd8,
    CMD_ANDI  = 5'd9,
    CMD_ORI   = 5'd10,
    CMD_SLTI  = 5'd11,
    CMD_SLTIU = 5'd12,
    CMD_LUI   = 5'd13,
    CMD_SLL   = 5'd14,
    CMD_SRL   = 5'd15,
    CMD_SRA   = 5'd16,
    CMD_DIV   = 5'd17,
    CMD_DIVU  = 5'd18,
    CMD_MFHI  = 5'd19,
    CMD_MFLO  = 5'd20,
    CMD_MTHI  = 5'd21,
    CMD_MTLO  = 5'd22
  } cmd_t;

  // Functions of the bit-serial ALU
  typedef enum logic [3:0] {
    FN_ADD,
    FN_SUB,
    FN_AND,
    FN_OR,
    FN_SLT,
    FN_SLTU,
    FN_SLL,
    FN_SRL,
    FN_SRA
  } alu_fn_t;

  // Which unit an instruction goes to
  typedef enum logic [1:0] {
    RT_ALU,
    RT_DIV,
    RT_DIRECT
  } route_t;

  // Sequencer states of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALU,
    ST_DIV,
    ST_OUT
  } top_state_t;

  // Divider states
  typedef enum logic [1:0] {
    DV_IDLE,
    DV_ITER,
    DV_SIGN
  } dv_state_t;

  // Launch request to the ALU
  typedef struct packed {
    logic       start;
    alu_fn_t    fn;
    logic [4:0] sa;
  } alu_req_t;

  // Launch request to the divider
  typedef struct packed {
    logic start;
    logic sgn;
  } div_req_t;

  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
  localparam int unsigned DATA_W   = 32;

endpackage

@@ rtl/iad_bit_alu.sv @@
`timescale 1ns / 1ps

module iad_bit_alu
  import iad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  alu_req_t    req_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] result_o,
  output logic        ovf_o
);

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  alu_fn_t     fn_r, fn_nxt;
  logic [31:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;
  logic [31:0] res_r, res_nxt;
  logic        carry_r, carry_nxt;
  logic        sa_r, sa_nxt;
  logic        sb_r, sb_nxt;
  logic        is_sub;
  logic        abit, bbit, sbit, rbit;
  logic        lt;

  // Subtract for sub and both compares
  always_comb begin
    is_sub = (req_i.fn inside {FN_SUB, FN_SLT, FN_SLTU});
  end

  // Advance one bit (or one shift position) per cycle
  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    fn_nxt    = fn_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    res_nxt   = res_r;
    carry_nxt = carry_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    abit      = a_r[0];
    bbit      = b_r[0];
    sbit      = abit ^ bbit ^ carry_r;
    rbit      = sbit;
    case (fn_r)
      FN_AND:  rbit = abit & bbit;
      FN_OR:   rbit = abit | bbit;
      default: rbit = sbit;
    endcase
    if (req_i.start) begin
      busy_nxt  = 1'b1;
      fn_nxt    = req_i.fn;
      a_nxt     = a_i;
      b_nxt     = is_sub ? ~b_i : b_i;
      carry_nxt = is_sub;
      res_nxt   = a_i;
      sa_nxt    = a_i[31];
      sb_nxt    = b_i[31];
      if (req_i.fn inside {FN_SLL, FN_SRL, FN_SRA}) begin
        cnt_nxt = {1'b0, req_i.sa};
      end else begin
        cnt_nxt = 6'(DATA_W);
      end
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
        case (fn_r)
          FN_SLL: res_nxt = {res_r[30:0], 1'b0};
          FN_SRL: res_nxt = {1'b0, res_r[31:1]};
          FN_SRA: res_nxt = {res_r[31], res_r[31:1]};
          default: begin
            res_nxt   = {rbit, res_r[31:1]};
            a_nxt     = {1'b0, a_r[31:1]};
            b_nxt     = {1'b0, b_r[31:1]};
            carry_nxt = (abit & bbit) | (abit & carry_r) | (bbit & carry_r);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    fn_r    <= fn_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    res_r   <= res_nxt;
    carry_r <= carry_nxt;
    sa_r    <= sa_nxt;
    sb_r    <= sb_nxt;
  end

  // Final carry out of the subtract is "no borrow"
  always_comb begin
    if (fn_r == FN_SLT && sa_r != sb_r) begin
      lt = sa_r;
    end else begin
      lt = ~carry_r;
    end
  end

  assign done_o   = busy_r && (cnt_r == 6'd0);
  assign result_o = (fn_r == FN_SLT || fn_r == FN_SLTU) ? {31'd0, lt} : res_r;
  assign ovf_o    = (fn_r == FN_ADD) && (sa_r == sb_r) && (res_r[31] != sa_r);

endmodule

@@ rtl/iad_divider.sv @@
`timescale 1ns / 1ps

module iad_divider
  import iad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);

  dv_state_t   state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] div_r, div_nxt;
  logic        neg_q_r, neg_q_nxt;
  logic        neg_r_r, neg_r_nxt;
  logic [32:0] shifted;
  logic [32:0] diff;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE: if (req_i.start) state_nxt = DV_ITER;
      DV_ITER: if (cnt_r == 5'd0) state_nxt = DV_SIGN;
      DV_SIGN: state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  // One quotient bit per cycle, restoring
  always_comb begin
    shifted   = {acc_r, quo_r[31]};
    diff      = shifted - {1'b0, div_r};
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    quo_nxt   = quo_r;
    div_nxt   = div_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    unique case (state_r)
      DV_IDLE: begin
        if (req_i.start) begin
          cnt_nxt   = 5'd31;
          acc_nxt   = '0;
          quo_nxt   = (req_i.sgn && dividend_i[31]) ? (~dividend_i + 32'd1) : dividend_i;
          div_nxt   = (req_i.sgn && divisor_i[31]) ? (~divisor_i + 32'd1) : divisor_i;
          neg_q_nxt = req_i.sgn && (dividend_i[31] ^ divisor_i[31]);
          neg_r_nxt = req_i.sgn && dividend_i[31];
        end
      end
      DV_ITER: begin
        cnt_nxt = cnt_r - 5'd1;
        if (!diff[32]) begin
          acc_nxt = diff[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          acc_nxt = shifted[31:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    quo_r   <= quo_nxt;
    div_r   <= div_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
  end

  // Apply signs on the last cycle
  assign done_o = (state_r == DV_SIGN);
  assign quo_o  = neg_q_r ? (~quo_r + 32'd1) : quo_r;
  assign rem_o  = neg_r_r ? (~acc_r + 32'd1) : acc_r;

endmodule

@@ rtl/integer_alu_with_divider_core.sv @@
`timescale 1ns / 1ps
// Integer ALU with HI/LO divider.
// Input channel (in_valid/in_ready) carries one instruction: command, both
// source values, a 16-bit immediate, a shift count and a destination index.
// Result channel (out_valid/out_ready) returns one transfer per instruction:
// result value, write enable and overflow flag. HI and LO are held inside.
// One instruction is in flight at a time; in_ready is high only when the
// sequencer is idle.
// Work between input transfer and out_valid:
//   add/sub/logic/compare/lui: 32 bit-serial steps in the ALU
//   sll/srl/sra: shift_amount steps in the ALU (one position per cycle)
//   div/divu: 32 radix-2 steps in the divider plus sign correction
//   mfhi/mflo/mthi/mtlo and unused codes: straight to the output stage
// in_ready returns as the result enters the output register.
// A finished result sits in the output register; if the receiver stalls, the
// next instruction is still taken and runs, and waits before the output
// register until the previous transfer completes.
// Synchronous reset clears HI, LO, the sequencer and out_valid.

module integer_alu_with_divider_core
  import iad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_command,
  input  logic [31:0] in_operand_s,
  input  logic [31:0] in_operand_t,
  input  logic [15:0] in_immediate,
  input  logic [4:0]  in_shift_amount,
  input  logic [4:0]  in_dest_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_value,
  output logic        out_write_enable,
  output logic        out_overflow_trap
);

  top_state_t  state_r, state_nxt;
  logic [31:0] hi_r, hi_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic        trap_r;
  logic        dest_nz_r;
  logic [31:0] hold_val_r;
  logic        hold_we_r;
  logic        hold_ovf_r;
  logic        out_valid_r;
  logic [31:0] out_val_r;
  logic        out_we_r;
  logic        out_ovf_r;

  logic        in_xfer;
  logic        out_load;
  route_t      dec_route;
  alu_fn_t     dec_fn;
  logic [31:0] dec_a;
  logic [31:0] dec_b;
  logic        dec_trap;
  logic        dec_sgn;
  logic [31:0] dec_val;
  logic        dec_we;
  logic [31:0] sext_imm;
  logic [31:0] zext_imm;
  logic        dest_nz;

  alu_req_t    alu_req;
  logic        alu_done;
  logic [31:0] alu_result;
  logic        alu_ovf;
  logic        alu_trap;
  div_req_t    div_req;
  logic        div_done;
  logic [31:0] div_quo;
  logic [31:0] div_rem;

  assign sext_imm = {{16{in_immediate[15]}}, in_immediate};
  assign zext_imm = {16'd0, in_immediate};
  assign dest_nz  = (in_dest_index != 5'd0);

  // Decode the instruction into a unit, a function and operands
  always_comb begin
    dec_route = RT_DIRECT;
    dec_fn    = FN_ADD;
    dec_a     = in_operand_s;
    dec_b     = in_operand_t;
    dec_trap  = 1'b0;
    dec_sgn   = 1'b0;
    dec_val   = '0;
    dec_we    = 1'b0;
    unique case (cmd_t'(in_command))
      CMD_ADD:   begin dec_route = RT_ALU; dec_trap = 1'b1; end
      CMD_ADDU:  dec_route = RT_ALU;
      CMD_SUBU:  begin dec_route = RT_ALU; dec_fn = FN_SUB; end
      CMD_AND:   begin dec_route = RT_ALU; dec_fn = FN_AND; end
      CMD_OR:    begin dec_route = RT_ALU; dec_fn = FN_OR; end
      CMD_SLT:   begin dec_route = RT_ALU; dec_fn = FN_SLT; end
      CMD_SLTU:  begin dec_route = RT_ALU; dec_fn = FN_SLTU; end
      CMD_ADDI:  begin dec_route = RT_ALU; dec_b = sext_imm; dec_trap = 1'b1; end
      CMD_ADDIU: begin dec_route = RT_ALU; dec_b = sext_imm; end
      CMD_ANDI:  begin dec_route = RT_ALU; dec_fn = FN_AND; dec_b = zext_imm; end
      CMD_ORI:   begin dec_route = RT_ALU; dec_fn = FN_OR; dec_b = zext_imm; end
      CMD_SLTI:  begin dec_route = RT_ALU; dec_fn = FN_SLT; dec_b = sext_imm; end
      CMD_SLTIU: begin dec_route = RT_ALU; dec_fn = FN_SLTU; dec_b = sext_imm; end
      CMD_LUI: begin
        dec_route = RT_ALU;
        dec_fn    = FN_OR;
        dec_a     = {in_immediate, 16'd0};
        dec_b     = '0;
      end
      CMD_SLL:   begin dec_route = RT_ALU; dec_fn = FN_SLL; dec_a = in_operand_t; end
      CMD_SRL:   begin dec_route = RT_ALU; dec_fn = FN_SRL; dec_a = in_operand_t; end
      CMD_SRA:   begin dec_route = RT_ALU; dec_fn = FN_SRA; dec_a = in_operand_t; end
      CMD_DIV:   begin dec_route = RT_DIV; dec_sgn = 1'b1; end
      CMD_DIVU:  dec_route = RT_DIV;
      CMD_MFHI:  begin dec_val = hi_r; dec_we = dest_nz; end
      CMD_MFLO:  begin dec_val = lo_r; dec_we = dest_nz; end
      CMD_MTHI:  dec_route = RT_DIRECT;
      CMD_MTLO:  dec_route = RT_DIRECT;
      default:   dec_route = RT_DIRECT;
    endcase
  end

  // Next state of the sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (dec_route)
            RT_ALU:  state_nxt = ST_ALU;
            RT_DIV:  state_nxt = ST_DIV;
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_ALU:  if (alu_done) state_nxt = ST_OUT;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_OUT:  out_load = !out_valid_r || out_ready;
      default: begin
      end
    endcase
  end

  assign in_xfer = in_valid && in_ready;

  // Launch the units
  always_comb begin
    alu_req.start = in_xfer && (dec_route == RT_ALU);
    alu_req.fn    = dec_fn;
    alu_req.sa    = in_shift_amount;
    div_req.start = in_xfer && (dec_route == RT_DIV);
    div_req.sgn   = dec_sgn;
  end

  iad_bit_alu u_alu (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_i    (alu_req),
    .a_i      (dec_a),
    .b_i      (dec_b),
    .done_o   (alu_done),
    .result_o (alu_result),
    .ovf_o    (alu_ovf)
  );

  iad_divider u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_i      (div_req),
    .dividend_i (in_operand_s),
    .divisor_i  (in_operand_t),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign alu_trap = trap_r && alu_ovf;

  // Update HI and LO
  always_comb begin
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    if (in_xfer && cmd_t'(in_command) == CMD_MTHI) begin
      hi_nxt = in_operand_s;
    end
    if (in_xfer && cmd_t'(in_command) == CMD_MTLO) begin
      lo_nxt = in_operand_s;
    end
    if (state_r == ST_DIV && div_done) begin
      hi_nxt = div_rem;
      lo_nxt = div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hi_r        <= '0;
      lo_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hi_r    <= hi_nxt;
      lo_r    <= lo_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the finished result until the output register is free
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      trap_r     <= dec_trap;
      dest_nz_r  <= dest_nz;
      hold_val_r <= dec_val;
      hold_we_r  <= dec_we;
      hold_ovf_r <= 1'b0;
    end else if (state_r == ST_ALU && alu_done) begin
      hold_val_r <= alu_trap ? 32'd0 : alu_result;
      hold_we_r  <= dest_nz_r && !alu_trap;
      hold_ovf_r <= alu_trap;
    end else if (state_r == ST_DIV && div_done) begin
      hold_val_r <= '0;
      hold_we_r  <= 1'b0;
      hold_ovf_r <= 1'b0;
    end
    if (out_load) begin
      out_val_r <= hold_val_r;
      out_we_r  <= hold_we_r;
      out_ovf_r <= hold_ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_value  = out_val_r;
  assign out_write_enable  = out_we_r;
  assign out_overflow_trap = out_ovf_r;

endmodule

@@ rtl/iad_checker.sv @@
`timescale 1ns / 1ps

module iad_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_value,
  input logic        out_write_enable,
  input logic        out_overflow_trap
);

  // A waiting result stays until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // One instruction in flight: no input right after a transfer
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // A trapped add never writes
  a_trap_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow_trap |-> !out_write_enable)
    else $error("write enabled on overflow");

  // A trapped add carries a zero value
  a_trap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow_trap |-> out_result_value == 32'd0)
    else $error("nonzero value on overflow");

endmodule

bind integer_alu_with_divider_core iad_checker u_iad_checker (.*);

@@ tb/sv/alu_result_checker.sv @@
`timescale 1ns / 1ps

module alu_result_checker
  import iad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [4:0]  in_command,
  input  logic [31:0] in_operand_s,
  input  logic [31:0] in_operand_t,
  input  logic [15:0] in_immediate,
  input  logic [4:0]  in_shift_amount,
  input  logic [4:0]  in_dest_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_result_value,
  input  logic        out_write_enable,
  input  logic        out_overflow_trap,
  output int          fail_count,
  output int          instr_count,
  output int          result_count
);

  typedef struct packed {
    logic [4:0]  cmd;
    logic [31:0] value;
    logic        we;
    logic        ovf;
  } alu_result_t;

  localparam int REPORT_LIMIT = 10;

  // Model copy of HI and LO
  logic [31:0] hi_word;
  logic [31:0] lo_word;

  alu_result_t expected_results[$];
  int          mismatches;

  // Compute the result of one instruction and update HI/LO as the block would
  function automatic alu_result_t predict_alu_result(input logic [4:0]  cmd,
                                                     input logic [31:0] s,
                                                     input logic [31:0] t,
                                                     input logic [15:0] imm,
                                                     input logic [4:0]  sa,
                                                     input logic [4:0]  dest);
    logic [31:0] se;
    logic [31:0] val;
    logic [31:0] carry_chk;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    logic [31:0] r;
    logic        writes;
    logic        ovf;
    alu_result_t res;
    se     = {{16{imm[15]}}, imm};
    val    = '0;
    writes = 1'b1;
    ovf    = 1'b0;
    case (cmd)
      CMD_ADD: begin
        val       = s + t;
        carry_chk = (s ^ val) & (t ^ val);
        ovf       = carry_chk[31];
      end
      CMD_ADDU:  val = s + t;
      CMD_SUBU:  val = s - t;
      CMD_AND:   val = s & t;
      CMD_OR:    val = s | t;
      CMD_SLT:   val = ($signed(s) < $signed(t)) ? 32'd1 : 32'd0;
      CMD_SLTU:  val = (s < t) ? 32'd1 : 32'd0;
      CMD_ADDI: begin
        val       = s + se;
        carry_chk = (s ^ val) & (se ^ val);
        ovf       = carry_chk[31];
      end
      CMD_ADDIU: val = s + se;
      CMD_ANDI:  val = s & {16'h0000, imm};
      CMD_ORI:   val = s | {16'h0000, imm};
      CMD_SLTI:  val = ($signed(s) < $signed(se)) ? 32'd1 : 32'd0;
      CMD_SLTIU: val = (s < se) ? 32'd1 : 32'd0;
      CMD_LUI:   val = {imm, 16'h0000};
      CMD_SLL:   val = t << sa;
      CMD_SRL:   val = t >> sa;
      CMD_SRA:   val = $unsigned($signed(t) >>> sa);
      CMD_DIV: begin
        writes = 1'b0;
        if (t == '0) begin
          // divide by zero: dividend to HI, LO depends on dividend sign
          hi_word = s;
          lo_word = s[31] ? 32'd1 : '1;
        end else if (s == SIGN_BIT && t == '1) begin
          hi_word = '0;
          lo_word = SIGN_BIT;
        end else begin
          // truncate toward zero, remainder follows the dividend
          ma      = s[31] ? -s : s;
          mb      = t[31] ? -t : t;
          q       = ma / mb;
          r       = ma % mb;
          lo_word = (s[31] ^ t[31]) ? -q : q;
          hi_word = s[31] ? -r : r;
        end
      end
      CMD_DIVU: begin
        writes = 1'b0;
        if (t == '0) begin
          hi_word = s;
          lo_word = '1;
        end else begin
          hi_word = s % t;
          lo_word = s / t;
        end
      end
      CMD_MFHI:  val = hi_word;
      CMD_MFLO:  val = lo_word;
      CMD_MTHI: begin
        hi_word = s;
        writes  = 1'b0;
      end
      CMD_MTLO: begin
        lo_word = s;
        writes  = 1'b0;
      end
      default:   writes = 1'b0;
    endcase
    if (ovf) begin
      val    = '0;
      writes = 1'b0;
    end
    res.cmd   = cmd;
    res.value = val;
    res.we    = writes && (dest != 5'd0);
    res.ovf   = ovf;
    return res;
  endfunction

  // Compare each result transfer with the oldest prediction, then queue new ones
  always @(posedge clk) begin
    alu_result_t exp_res;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      hi_word = '0;
      lo_word = '0;
      expected_results.delete();
      mismatches = 0;
      fail_count   <= 0;
      instr_count  <= 0;
      result_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errs++;
          if (mismatches < REPORT_LIMIT)
            $display("%0t: result transfer with nothing expected: value %08h we %0b ovf %0b",
                     $realtime, out_result_value, out_write_enable, out_overflow_trap);
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_result_value !== exp_res.value || out_write_enable !== exp_res.we ||
              out_overflow_trap !== exp_res.ovf) begin
            errs++;
            if (mismatches < REPORT_LIMIT)
              $display("%0t: cmd %0d expected value %08h we %0b ovf %0b, got %08h %0b %0b",
                       $realtime, exp_res.cmd, exp_res.value, exp_res.we, exp_res.ovf,
                       out_result_value, out_write_enable, out_overflow_trap);
            mismatches++;
          end
        end
        result_count <= result_count + 1;
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_alu_result(in_command, in_operand_s,
                                                      in_operand_t, in_immediate,
                                                      in_shift_amount, in_dest_index));
        instr_count <= instr_count + 1;
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

@@ tb/sv/tb_integer_alu_with_divider_core.sv @@
`timescale 1ns / 1ps

module tb_integer_alu_with_divider_core
  import iad_pkg::*;
();

  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  in_command = '0;
  logic [31:0] in_operand_s = '0;
  logic [31:0] in_operand_t = '0;
  logic [15:0] in_immediate = '0;
  logic [4:0]  in_shift_amount = '0;
  logic [4:0]  in_dest_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_result_value;
  logic        out_write_enable;
  logic        out_overflow_trap;

  int fail_count;
  int instr_count;
  int result_count;
  int in_idle_pct = 8;
  int out_idle_pct = 8;
  int divides_sent = 0;

  integer_alu_with_divider_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_operand_s     (in_operand_s),
    .in_operand_t     (in_operand_t),
    .in_immediate     (in_immediate),
    .in_shift_amount  (in_shift_amount),
    .in_dest_index    (in_dest_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_write_enable (out_write_enable),
    .out_overflow_trap(out_overflow_trap)
  );

  alu_result_checker result_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_operand_s     (in_operand_s),
    .in_operand_t     (in_operand_t),
    .in_immediate     (in_immediate),
    .in_shift_amount  (in_shift_amount),
    .in_dest_index    (in_dest_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_write_enable (out_write_enable),
    .out_overflow_trap(out_overflow_trap),
    .fail_count       (fail_count),
    .instr_count      (instr_count),
    .result_count     (result_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Drive one instruction and hold it until the transfer
  task automatic send_instr(input logic [4:0]  cmd,
                            input logic [31:0] s,
                            input logic [31:0] t,
                            input logic [15:0] imm,
                            input logic [4:0]  sa,
                            input logic [4:0]  dest);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < in_idle_pct) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_operand_s    <= s;
    in_operand_t    <= t;
    in_immediate    <= imm;
    in_shift_amount <= sa;
    in_dest_index   <= dest;
    if (cmd == CMD_DIV || cmd == CMD_DIVU) divides_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and hold until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (instr_count != result_count) @(posedge clk);
  endtask

  // Operand values biased toward the corners
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(11))
      0:       v = 32'h0000_0000;
      1:       v = 32'h0000_0001;
      2:       v = 32'hffff_ffff;
      3:       v = SIGN_BIT;
      4:       v = 32'h7fff_ffff;
      5:       v = 32'($urandom_range(15));
      6:       v = -32'($urandom_range(15));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_imm();
    logic [15:0] v;
    case ($urandom_range(7))
      0:       v = 16'h0000;
      1:       v = 16'hffff;
      2:       v = 16'h8000;
      3:       v = 16'h7fff;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  initial begin
    int          sent;
    int          r;
    logic [4:0]  cmd;
    logic [4:0]  dest;
    logic        paused;
    sent   = 0;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: overflow both ways, zero destination, limits of each op
    send_instr(CMD_ADD,   32'h7fff_ffff, 32'h0000_0001, 16'h0000, 5'd0,  5'd5);
    send_instr(CMD_ADDI,  SIGN_BIT,      32'h0000_0000, 16'h8000, 5'd0,  5'd31);
    send_instr(CMD_ADDU,  32'hffff_ffff, 32'h0000_0001, 16'h0000, 5'd0,  5'd0);
    send_instr(CMD_SUBU,  32'h0000_0000, 32'h0000_0001, 16'hffff, 5'd31, 5'd1);
    send_instr(CMD_AND,   32'hffff_ffff, 32'ha5a5_a5a5, 16'h0000, 5'd0,  5'd2);
    send_instr(CMD_OR,    32'h0000_0000, 32'h8000_0001, 16'h0000, 5'd0,  5'd3);
    send_instr(CMD_SLT,   SIGN_BIT,      32'h0000_0001, 16'h0000, 5'd0,  5'd4);
    send_instr(CMD_SLTU,  SIGN_BIT,      32'h0000_0001, 16'h0000, 5'd0,  5'd4);
    send_instr(CMD_ADDIU, 32'h0000_0000, 32'h0000_0000, 16'hffff, 5'd0,  5'd6);
    send_instr(CMD_ANDI,  32'hffff_ffff, 32'h0000_0000, 16'hffff, 5'd0,  5'd7);
    send_instr(CMD_ORI,   32'h0000_0000, 32'h0000_0000, 16'h8000, 5'd0,  5'd8);
    send_instr(CMD_SLTI,  32'hffff_fffe, 32'h0000_0000, 16'hffff, 5'd0,  5'd9);
    send_instr(CMD_SLTIU, 32'h0000_0001, 32'h0000_0000, 16'hffff, 5'd0,  5'd10);
    send_instr(CMD_LUI,   32'h0000_0000, 32'h0000_0000, 16'hffff, 5'd0,  5'd11);
    send_instr(CMD_SLL,   32'h0000_0000, 32'h0000_0001, 16'h0000, 5'd31, 5'd12);
    send_instr(CMD_SRL,   32'h0000_0000, 32'hffff_ffff, 16'h0000, 5'd31, 5'd13);
    send_instr(CMD_SRA,   32'h0000_0000, SIGN_BIT,      16'h0000, 5'd31, 5'd14);
    // Most negative over minus one, then signed and unsigned divide by zero
    send_instr(CMD_DIV,   SIGN_BIT,      32'hffff_ffff, 16'h0000, 5'd0,  5'd15);
    send_instr(CMD_MFHI,  32'h0000_0000, 32'h0000_0000, 16'h0000, 5'd0,  5'd16);
    send_instr(CMD_DIV,   32'hffff_fff9, 32'h0000_0000, 16'h0000, 5'd0,  5'd17);
    send_instr(CMD_MFLO,  32'h0000_0000, 32'h0000_0000, 16'h0000, 5'd0,  5'd18);
    send_instr(CMD_DIVU,  32'hffff_ffff, 32'h0000_0000, 16'h0000, 5'd0,  5'd19);
    send_instr(CMD_MFLO,  32'h0000_0000, 32'h0000_0000, 16'h0000, 5'd0,  5'd20);
    // Signed divide with negative dividend, then direct HI/LO moves
    send_instr(CMD_DIV,   32'hffff_fff9, 32'h0000_0002, 16'h0000, 5'd0,  5'd21);
    send_instr(CMD_MFHI,  32'h0000_0000, 32'h0000_0000, 16'h0000, 5'd0,  5'd22);
    send_instr(CMD_MTHI,  32'hdead_beef, 32'h0000_0000, 16'h0000, 5'd0,  5'd23);
    send_instr(CMD_MTLO,  32'h0000_0000, 32'h0000_0000, 16'h0000, 5'd0,  5'd24);
    send_instr(CMD_MFHI,  32'h0000_0000, 32'h0000_0000, 16'h0000, 5'd0,  5'd25);
    send_instr(5'd31,     32'hffff_ffff, 32'hffff_ffff, 16'hffff, 5'd31, 5'd31);

    // Random instruction stream; divides and moves are followed by HI/LO reads three times in four
    while (sent < RANDOM_ITEMS) begin
      if (sent >= 400 && sent < 700) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = 8;
        out_idle_pct = 8;
      end
      if (!paused && sent >= 800) begin
        drain_results();
        paused = 1'b1;
      end
      r    = $urandom_range(99);
      dest = 5'($urandom);
      if (r < 4) begin
        cmd = 5'(CMD_MTLO) + 5'($urandom_range(1, 9));
      end else if (r < 16) begin
        cmd = ($urandom_range(1) != 0) ? CMD_DIV : CMD_DIVU;
      end else if (r < 24) begin
        cmd = ($urandom_range(1) != 0) ? CMD_MTHI : CMD_MTLO;
      end else if (r < 30) begin
        cmd = ($urandom_range(1) != 0) ? CMD_MFHI : CMD_MFLO;
      end else begin
        cmd = 5'($urandom_range(CMD_SRA));
      end
      send_instr(cmd, pick_operand(), pick_operand(), pick_imm(), 5'($urandom), dest);
      sent++;
      if (cmd == CMD_DIV || cmd == CMD_DIVU || cmd == CMD_MTHI || cmd == CMD_MTLO) begin
        if ($urandom_range(3) != 0) begin
          send_instr(CMD_MFLO, $urandom, $urandom, 16'($urandom), 5'($urandom),
                     5'($urandom_range(1, 31)));
          send_instr(CMD_MFHI, $urandom, $urandom, 16'($urandom), 5'($urandom),
                     5'($urandom_range(1, 31)));
          sent += 2;
        end
      end
    end

    // Wait for the last results, then allow for stray transfers
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d instructions (%0d divides) with random stalls on both channels,",
             instr_count, divides_sent);
    $display("%0d results compared against the predicted value, write enable and overflow",
             result_count);
    if (fail_count == 0 && instr_count == result_count) begin
      $display("tb_integer_alu_with_divider_core OK");
    end else begin
      $display("tb_integer_alu_with_divider_core NOT OK");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("Timeout with %0d instructions and %0d results", instr_count, result_count);
    $display("tb_integer_alu_with_divider_core NOT OK");
    $finish;
  end

endmodule
